[sv/scfg_pkg.sv]
`timescale 1ns / 1ps
package scfg_pkg;

  localparam logic [7:0] DEV_FDC   = 8'd0;
  localparam logic [7:0] DEV_LPT   = 8'd1;
  localparam logic [7:0] DEV_UART2 = 8'd2;
  localparam logic [7:0] DEV_UART1 = 8'd3;
  localparam logic [7:0] DEV_PM    = 8'd4;
  localparam logic [7:0] DEV_MOUSE = 8'd5;
  localparam logic [7:0] DEV_KBD   = 8'd6;
  localparam int         ACT_COUNT = 7;

  localparam logic [7:0] GREG_SWRESET = 8'h00;
  localparam logic [7:0] GREG_W02     = 8'h02;
  localparam logic [7:0] GREG_W03     = 8'h03;
  localparam logic [7:0] GREG_06      = 8'h06;
  localparam logic [7:0] GREG_DEVSEL  = 8'h07;
  localparam logic [7:0] GREG_ID      = 8'h20;
  localparam logic [7:0] GREG_WINDOW  = 8'h21;
  localparam logic [7:0] GREG_22      = 8'h22;
  localparam logic [7:0] DEV_BASE     = 8'h30;

  localparam logic [7:0] WIN_BASE_STRAP0 = 8'h0b;
  localparam logic [7:0] WIN_BASE_STRAP1 = 8'h0a;
  localparam logic [7:0] WIN_PS2_BIT     = 8'h04;

  localparam logic [1:0] WIN_NONE = 2'd0;
  localparam logic [1:0] WIN_15C  = 2'd1;
  localparam logic [1:0] WIN_2E   = 2'd2;

  localparam logic [7:0] PM0_RESET = 8'h79;
  localparam logic [7:0] PM4_RESET = 8'h0e;
  localparam int         PM_DEPTH  = 8;

  localparam logic [7:0] CFG_CHIP_ID = 8'd0;
  localparam logic [7:0] CFG_STRAP   = 8'd1;

  typedef struct packed {
    logic       valid;
    logic       wr;
    logic [7:0] ptr;
    logic [7:0] data;
  } dev_req_t;

  typedef struct packed {
    logic                 busy;
    logic [ACT_COUNT-1:0] act;
  } dev_stat_t;

  // Writable bits of a device register, keyed on the pointer value.
  function automatic logic [7:0] wmask(logic [7:0] dv, logic [7:0] ptr);
    logic [7:0] m;
    m = 8'h00;
    case (ptr)
      8'h30: m = (dv <= DEV_KBD) ? 8'hff : 8'h00;
      8'h31: m = (dv <= DEV_PM) ? 8'hff : 8'h00;
      8'h60: begin
        if (dv == DEV_LPT) m = 8'h03;
        else m = (dv <= DEV_PM || dv == DEV_KBD) ? 8'hff : 8'h00;
      end
      8'h61: begin
        if (dv == DEV_KBD) m = 8'hfb;
        else if (dv == DEV_FDC || dv == DEV_UART2 || dv == DEV_UART1) m = 8'hf8;
        else if (dv == DEV_LPT) m = 8'hfc;
        else if (dv == DEV_PM) m = 8'hfe;
        else m = 8'h00;
      end
      8'h62: m = (dv == DEV_KBD) ? 8'hff : 8'h00;
      8'h63: m = (dv == DEV_KBD) ? 8'hfb : 8'h00;
      8'h70: m = (dv <= DEV_KBD && dv != DEV_PM) ? 8'hff : 8'h00;
      8'h71: begin
        if (dv == DEV_MOUSE) m = 8'h03;
        else m = (dv <= DEV_PM) ? 8'h02 : 8'h00;
      end
      8'h74: m = (dv <= DEV_UART2) ? 8'hff : 8'h00;
      8'h75: m = (dv == DEV_UART2) ? 8'hff : 8'h00;
      8'hf0: m = (dv <= DEV_UART1 || dv == DEV_KBD) ? 8'hff : 8'h00;
      8'hf1: m = (dv == DEV_FDC) ? 8'hff : 8'h00;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Power-on defaults of the device registers, keyed on the device offset.
  function automatic logic [7:0] dflt_val(logic [7:0] dv, logic [7:0] off);
    logic [15:0] k;
    logic [7:0]  v;
    k = {dv, off};
    v = 8'h00;
    case (k)
      16'h0600: v = 8'h01;  16'h0631: v = 8'h60;  16'h0633: v = 8'h64;
      16'h0640: v = 8'h01;  16'h0641: v = 8'h02;  16'h0644: v = 8'h04;
      16'h0645: v = 8'h04;  16'h06c0: v = 8'h40;
      16'h0540: v = 8'h0c;  16'h0541: v = 8'h02;  16'h0544: v = 8'h04;
      16'h0545: v = 8'h04;
      16'h0001: v = 8'h01;  16'h0030: v = 8'h03;  16'h0031: v = 8'hf0;
      16'h0032: v = 8'h03;  16'h0033: v = 8'hf7;  16'h0040: v = 8'h06;
      16'h0041: v = 8'h03;  16'h0044: v = 8'h02;  16'h0045: v = 8'h04;
      16'h00c0: v = 8'h02;
      16'h0130: v = 8'h02;  16'h0131: v = 8'h78;  16'h0140: v = 8'h07;
      16'h0144: v = 8'h04;  16'h0145: v = 8'h04;  16'h01c0: v = 8'hf2;
      16'h0230: v = 8'h02;  16'h0231: v = 8'hf8;  16'h0240: v = 8'h03;
      16'h0241: v = 8'h03;  16'h0244: v = 8'h04;  16'h0245: v = 8'h04;
      16'h02c0: v = 8'h02;
      16'h0330: v = 8'h03;  16'h0331: v = 8'hf8;  16'h0340: v = 8'h04;
      16'h0341: v = 8'h03;  16'h0344: v = 8'h04;  16'h0345: v = 8'h04;
      16'h03c0: v = 8'h02;
      16'h0444: v = 8'h04;  16'h0445: v = 8'h04;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[sv/superio_config_register_file_top.sv]
`timescale 1ns / 1ps
// Super I/O configuration space: index/data pairs for the configuration
// registers (window_sel 0) and the power-management registers (window_sel 1).
// Input transactions carry req_type, window_sel, data_port and write_data
// under in_valid/in_stall; every transaction gives exactly one result under
// out_valid/out_stall with the read byte and the decoded block status.
// One transaction at a time. A data-port access to a register of a logical
// device in range goes through S_MEM before S_DONE: the device RAM is read at
// acceptance, and in S_MEM the read byte is captured and a write is merged
// under the writable-bit mask and written back. Every other access goes
// straight to S_DONE. A new transaction is accepted only in S_IDLE.
// A result waits in the output register while out_stall is high; the next
// transaction is accepted meanwhile and its result is held until the
// output register frees.
// After reset the device RAM is loaded with its power-on defaults, one entry
// a cycle, DEVICE_COUNT * 2**clog2(DEVICE_SPAN) entries; in_stall stays high
// throughout. The cfg write port (cfg_index 0 chip id, 1 window strap) is
// always ready and must be written only while idle; the block does not check.
module superio_config_register_file_top #(
  parameter int DEVICE_COUNT = 8,
  parameter int DEVICE_SPAN  = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic       window_sel,
  input  logic       data_port,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [1:0] config_window,
  output logic       fdc_ps2_mode,
  output logic       fdc_enabled,
  output logic       lpt_enabled,
  output logic       uart1_enabled,
  output logic       uart2_enabled,
  output logic       kbd_enabled,
  output logic       mouse_enabled,
  output logic       pm_enabled,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import scfg_pkg::*;

  localparam int DEV_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MEM  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [7:0] reg_pointer;
  logic [2:0] pm_pointer;
  logic [7:0] pm_regs [PM_DEPTH];
  logic [7:0] g06, g07, g20, g21, g22;
  logic [7:0] rd_hold;
  logic       item_wr;

  dev_req_t   dreq;
  dev_stat_t  dstat;
  logic [7:0] dev_rdata;

  logic       accept;
  logic       dev_ok;
  logic       mem_hit;
  logic       out_free;
  logic [7:0] g_read;
  logic [7:0] g21_sel;
  logic       kbd_on;
  logic [7:0] strap_val;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE) || dstat.busy;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign dev_ok    = {1'b0, g07} < 9'(DEVICE_COUNT);
  assign mem_hit   = !window_sel && data_port && reg_pointer >= DEV_BASE && dev_ok;
  assign strap_val = WIN_PS2_BIT | (cfg_data[0] ? WIN_BASE_STRAP1 : WIN_BASE_STRAP0);

  assign dreq.valid = accept && mem_hit;
  assign dreq.wr    = req_type;
  assign dreq.ptr   = reg_pointer;
  assign dreq.data  = write_data;

  scfg_dev_bank #(.DEVICE_COUNT(DEVICE_COUNT), .DEVICE_SPAN(DEVICE_SPAN)) u_bank (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .dev  (g07[DEV_W-1:0]),
    .rdata(dev_rdata),
    .stat (dstat)
  );

  always_comb begin
    case (reg_pointer)
      GREG_06:     g_read = g06;
      GREG_DEVSEL: g_read = g07;
      GREG_ID:     g_read = g20;
      GREG_WINDOW: g_read = g21;
      GREG_22:     g_read = g22;
      default:     g_read = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      reg_pointer <= 8'h00;
      pm_pointer  <= 3'd0;
      g06 <= 8'h00;
      g07 <= 8'h00;
      g20 <= 8'h00;
      g21 <= WIN_PS2_BIT | WIN_BASE_STRAP0;
      g22 <= 8'h00;
      for (int i = 0; i < PM_DEPTH; i++)
        pm_regs[i] <= (i == 0) ? PM0_RESET : (i == 4) ? PM4_RESET : 8'h00;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CHIP_ID) g20 <= cfg_data;
        else if (cfg_index == CFG_STRAP) g21 <= strap_val;
      end
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= mem_hit ? S_MEM : S_DONE;
            if (window_sel) begin
              if (req_type) begin
                if (data_port) pm_regs[pm_pointer] <= write_data;
                else pm_pointer <= write_data[2:0];
              end
            end else if (req_type) begin
              if (!data_port) begin
                reg_pointer <= write_data;
              end else begin
                case (reg_pointer)
                  GREG_06:     g06 <= write_data;
                  GREG_DEVSEL: g07 <= write_data;
                  GREG_WINDOW: g21 <= write_data;
                  GREG_22:     g22 <= write_data;
                  default: ;
                endcase
              end
            end
          end
        end
        S_MEM:  state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Read byte of the transaction; device reads are captured in S_MEM.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      item_wr <= req_type;
      if (req_type) rd_hold <= 8'h00;
      else if (window_sel) rd_hold <= data_port ? pm_regs[pm_pointer] : 8'(pm_pointer);
      else if (!data_port) rd_hold <= reg_pointer;
      else if (reg_pointer >= DEV_BASE) rd_hold <= 8'h00;
      else rd_hold <= g_read;
    end else if (state == S_MEM) begin
      rd_hold <= item_wr ? 8'h00 : dev_rdata;
    end
  end

  assign g21_sel = g21 & (WIN_BASE_STRAP0);
  assign kbd_on  = dstat.act[DEV_KBD[2:0]] && pm_regs[0][0];

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      read_data <= rd_hold;
      case (g21_sel)
        8'h02, 8'h08, 8'h0a: config_window <= WIN_15C;
        8'h03, 8'h09, 8'h0b: config_window <= WIN_2E;
        default:             config_window <= WIN_NONE;
      endcase
      fdc_ps2_mode  <= !g21[2];
      fdc_enabled   <= dstat.act[DEV_FDC[2:0]] && pm_regs[0][3];
      lpt_enabled   <= dstat.act[DEV_LPT[2:0]] && pm_regs[0][4];
      uart1_enabled <= dstat.act[DEV_UART1[2:0]] && pm_regs[0][6];
      uart2_enabled <= dstat.act[DEV_UART2[2:0]] && pm_regs[0][5];
      kbd_enabled   <= kbd_on;
      mouse_enabled <= kbd_on && dstat.act[DEV_MOUSE[2:0]];
      pm_enabled    <= dstat.act[DEV_PM[2:0]];
    end
  end

  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    dstat.busy |-> in_stall) else $error("transaction taken during RAM load");
  a_mem_path: assert property (@(posedge clk) disable iff (rst)
    (accept && mem_hit) |=> state == S_MEM) else $error("device access skipped RAM");
  a_mem_done: assert property (@(posedge clk) disable iff (rst)
    state == S_MEM |=> state == S_DONE) else $error("RAM cycle did not finish");
  a_chip_id: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == CFG_CHIP_ID) |=> g20 == $past(cfg_data))
    else $error("chip id not loaded");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> out_valid && state == S_IDLE)
    else $error("result not presented");
endmodule

[sv/scfg_ram.sv]
`timescale 1ns / 1ps
module scfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/scfg_dev_bank.sv]
`timescale 1ns / 1ps
module scfg_dev_bank #(
  parameter int DEVICE_COUNT = 8,
  parameter int DEVICE_SPAN  = 256,
  localparam int DEV_W  = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1,
  localparam int SPAN_W = $clog2(DEVICE_SPAN)
) (
  input  logic                clk,
  input  logic                rst,
  input  scfg_pkg::dev_req_t  req,
  input  logic [DEV_W-1:0]    dev,
  output logic [7:0]          rdata,
  output scfg_pkg::dev_stat_t stat
);
  import scfg_pkg::*;

  localparam int ADDR_W = DEV_W + SPAN_W;
  localparam int DEPTH  = DEVICE_COUNT * (2 ** SPAN_W);

  logic              init;
  logic [ADDR_W-1:0] cnt;
  logic              pend;
  logic              pend_wr;
  logic [7:0]        pend_ptr;
  logic [7:0]        pend_data;
  logic [DEV_W-1:0]  pend_dev;
  logic [ACT_COUNT-1:0] act;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        req_off;
  logic [7:0]        pend_off;
  logic [7:0]        merged;
  logic [7:0]        mask;
  logic [7:0]        init_dev;
  logic [7:0]        init_off;
  logic [7:0]        init_val;

  assign req_off  = req.ptr - DEV_BASE;
  assign pend_off = pend_ptr - DEV_BASE;
  assign raddr    = {dev, req_off[SPAN_W-1:0]};
  assign mask     = wmask(8'(pend_dev), pend_ptr);
  assign merged   = (rdata & ~mask) | (pend_data & mask);
  assign init_dev = 8'(cnt[ADDR_W-1:SPAN_W]);
  assign init_off = 8'(cnt[SPAN_W-1:0]);
  assign init_val = dflt_val(init_dev, init_off);

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = init_val;
    if (init) begin
      we = 1'b1;
    end else if (pend && pend_wr) begin
      we    = 1'b1;
      waddr = {pend_dev, pend_off[SPAN_W-1:0]};
      wdata = merged;
    end
  end

  scfg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init <= 1'b1;
      cnt  <= '0;
      pend <= 1'b0;
      act  <= '0;
    end else begin
      pend <= req.valid;
      if (init) begin
        if (init_off == 8'h00 && init_dev < 8'(ACT_COUNT)) act[init_dev[2:0]] <= init_val[0];
        if (cnt == ADDR_W'(DEPTH - 1)) init <= 1'b0;
        cnt <= cnt + 1'b1;
      end else if (pend && pend_wr && pend_off == 8'h00 &&
                   8'(pend_dev) < 8'(ACT_COUNT)) begin
        act[pend_dev[2:0]] <= merged[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      pend_wr   <= req.wr;
      pend_ptr  <= req.ptr;
      pend_data <= req.data;
      pend_dev  <= dev;
    end
  end

  assign stat.busy = init;
  assign stat.act  = act;
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import scfg_pkg::*;

  localparam bit ACC_RD = 1'b0, ACC_WR = 1'b1;
  localparam bit PAIR_CFG = 1'b0, PAIR_PM = 1'b1;
  localparam bit PORT_IDX = 1'b0, PORT_DAT = 1'b1;
  localparam int NDEV = 8;
  localparam int WATCHDOG = 20000;
  localparam int PHASE_ITEMS = 470;

  typedef struct {
    logic [7:0] rd;
    logic [1:0] win;
    logic       ps2, fdc, lpt, uart1, uart2, kbd, mouse, pm;
  } status_t;

  typedef struct {
    bit rt, ws, dp;
    logic [7:0] wd;
    bit typed;
    logic [7:0] rd;
  } row_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, req_type = 1'b0, window_sel = 1'b0, data_port = 1'b0;
  logic [7:0] write_data = 8'h00;
  logic out_stall = 1'b0, cfg_valid = 1'b0;
  logic [7:0] cfg_index = 8'h00, cfg_data = 8'h00;
  logic in_stall, out_valid, cfg_ready;
  logic [7:0] read_data;
  logic [1:0] config_window;
  logic fdc_ps2_mode, fdc_enabled, lpt_enabled, uart1_enabled, uart2_enabled;
  logic kbd_enabled, mouse_enabled, pm_enabled;

  superio_config_register_file_top dut (.*);

  always #1 clk = ~clk;

  // shadow state
  logic [7:0] sh_ptr, sh_pm_ptr, sh_id;
  bit         sh_strap;
  logic [7:0] sh_glob [48];
  logic [7:0] sh_dev [NDEV][256];
  logic [7:0] sh_pm [8];

  status_t pending_q[$];
  int errors = 0, accepted = 0, taken = 0, cfg_done = 0, idle_cycles = 0;
  int out_hold = 0;
  bit calm = 1'b0, cur_typed = 1'b0;
  logic [7:0] cur_rd = 8'h00;

  function automatic logic [7:0] window_bits();
    return 8'h04 | (sh_strap ? WIN_BASE_STRAP1 : WIN_BASE_STRAP0);
  endfunction

  function automatic logic [7:0] writable_bits(logic [7:0] dv, logic [7:0] p);
    case (p)
      8'h30: return dv <= DEV_KBD ? 8'hff : 8'h00;
      8'h31: return dv <= DEV_PM ? 8'hff : 8'h00;
      8'h60: return dv == DEV_LPT ? 8'h03 : (dv <= DEV_PM || dv == DEV_KBD) ? 8'hff : 8'h00;
      8'h61: begin
        if (dv == DEV_KBD) return 8'hfb;
        if (dv == DEV_FDC || dv == DEV_UART2 || dv == DEV_UART1) return 8'hf8;
        if (dv == DEV_LPT) return 8'hfc;
        if (dv == DEV_PM) return 8'hfe;
        return 8'h00;
      end
      8'h62: return dv == DEV_KBD ? 8'hff : 8'h00;
      8'h63: return dv == DEV_KBD ? 8'hfb : 8'h00;
      8'h70: return (dv <= DEV_KBD && dv != DEV_PM) ? 8'hff : 8'h00;
      8'h71: return dv == DEV_MOUSE ? 8'h03 : dv <= DEV_PM ? 8'h02 : 8'h00;
      8'h74: return dv <= DEV_UART2 ? 8'hff : 8'h00;
      8'h75: return dv == DEV_UART2 ? 8'hff : 8'h00;
      8'hf0: return (dv <= DEV_UART1 || dv == DEV_KBD) ? 8'hff : 8'h00;
      8'hf1: return dv == DEV_FDC ? 8'hff : 8'h00;
      default: return 8'h00;
    endcase
  endfunction

  task automatic power_on_state();
    sh_ptr = 0; sh_pm_ptr = 0; sh_id = 0; sh_strap = 0;
    foreach (sh_glob[i]) sh_glob[i] = 0;
    foreach (sh_dev[d, o]) sh_dev[d][o] = 0;
    foreach (sh_pm[i]) sh_pm[i] = 0;
    sh_glob[GREG_ID] = 0;
    sh_glob[GREG_WINDOW] = window_bits();
    sh_pm[0] = PM0_RESET; sh_pm[4] = PM4_RESET;
    sh_dev[6][8'h00] = 8'h01; sh_dev[6][8'h31] = 8'h60; sh_dev[6][8'h33] = 8'h64;
    sh_dev[6][8'h40] = 8'h01; sh_dev[6][8'h41] = 8'h02; sh_dev[6][8'h44] = 8'h04;
    sh_dev[6][8'h45] = 8'h04; sh_dev[6][8'hc0] = 8'h40;
    sh_dev[5][8'h40] = 8'h0c; sh_dev[5][8'h41] = 8'h02; sh_dev[5][8'h44] = 8'h04;
    sh_dev[5][8'h45] = 8'h04;
    sh_dev[0][8'h01] = 8'h01; sh_dev[0][8'h30] = 8'h03; sh_dev[0][8'h31] = 8'hf0;
    sh_dev[0][8'h32] = 8'h03; sh_dev[0][8'h33] = 8'hf7; sh_dev[0][8'h40] = 8'h06;
    sh_dev[0][8'h41] = 8'h03; sh_dev[0][8'h44] = 8'h02; sh_dev[0][8'h45] = 8'h04;
    sh_dev[0][8'hc0] = 8'h02;
    sh_dev[1][8'h30] = 8'h02; sh_dev[1][8'h31] = 8'h78; sh_dev[1][8'h40] = 8'h07;
    sh_dev[1][8'h44] = 8'h04; sh_dev[1][8'h45] = 8'h04; sh_dev[1][8'hc0] = 8'hf2;
    sh_dev[2][8'h30] = 8'h02; sh_dev[2][8'h31] = 8'hf8; sh_dev[2][8'h40] = 8'h03;
    sh_dev[2][8'h41] = 8'h03; sh_dev[2][8'h44] = 8'h04; sh_dev[2][8'h45] = 8'h04;
    sh_dev[2][8'hc0] = 8'h02;
    sh_dev[3][8'h30] = 8'h03; sh_dev[3][8'h31] = 8'hf8; sh_dev[3][8'h40] = 8'h04;
    sh_dev[3][8'h41] = 8'h03; sh_dev[3][8'h44] = 8'h04; sh_dev[3][8'h45] = 8'h04;
    sh_dev[3][8'hc0] = 8'h02;
    sh_dev[4][8'h44] = 8'h04; sh_dev[4][8'h45] = 8'h04;
  endtask

  function automatic bit dev_on(int d);
    return sh_dev[d][0][0];
  endfunction

  function automatic status_t access_status(bit rt, bit ws, bit dp, logic [7:0] wd);
    status_t s;
    logic [7:0] sel, off;
    s.rd = 8'h00;
    sel = sh_glob[GREG_DEVSEL];
    off = sh_ptr - DEV_BASE;
    if (ws == PAIR_PM) begin
      if (rt == ACC_WR) begin
        if (dp == PORT_DAT) sh_pm[sh_pm_ptr[2:0]] = wd;
        else sh_pm_ptr = {5'b0, wd[2:0]};
      end else s.rd = dp == PORT_DAT ? sh_pm[sh_pm_ptr[2:0]] : sh_pm_ptr;
    end else if (dp == PORT_IDX) begin
      if (rt == ACC_WR) sh_ptr = wd;
      else s.rd = sh_ptr;
    end else if (sh_ptr >= DEV_BASE) begin
      if (sel < NDEV) begin
        if (rt == ACC_WR)
          sh_dev[sel][off] = (sh_dev[sel][off] & ~writable_bits(sel, sh_ptr))
                             | (wd & writable_bits(sel, sh_ptr));
        else s.rd = sh_dev[sel][off];
      end
    end else if (rt == ACC_WR) begin
      if (sh_ptr inside {GREG_SWRESET, GREG_W02, GREG_W03, GREG_06, GREG_DEVSEL,
                         GREG_WINDOW, GREG_22})
        sh_glob[sh_ptr] = wd;
    end else if (!(sh_ptr inside {GREG_SWRESET, GREG_W02, GREG_W03})) begin
      s.rd = sh_glob[sh_ptr];
    end
    case (sh_glob[GREG_WINDOW] & 8'h0b)
      8'h02, 8'h08, 8'h0a: s.win = WIN_15C;
      8'h03, 8'h09, 8'h0b: s.win = WIN_2E;
      default: s.win = WIN_NONE;
    endcase
    s.ps2   = ~sh_glob[GREG_WINDOW][2];
    s.fdc   = dev_on(DEV_FDC) & sh_pm[0][3];
    s.lpt   = dev_on(DEV_LPT) & sh_pm[0][4];
    s.uart1 = dev_on(DEV_UART1) & sh_pm[0][6];
    s.uart2 = dev_on(DEV_UART2) & sh_pm[0][5];
    s.kbd   = dev_on(DEV_KBD) & sh_pm[0][0];
    s.mouse = s.kbd & dev_on(DEV_MOUSE);
    s.pm    = dev_on(DEV_PM);
    return s;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    status_t e;
    if (rst) idle_cycles <= 0;
    else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CHIP_ID) begin
          sh_id = cfg_data; sh_glob[GREG_ID] = cfg_data;
        end else if (cfg_index == CFG_STRAP) begin
          sh_strap = cfg_data[0]; sh_glob[GREG_WINDOW] = window_bits();
        end
        cfg_done++;
      end
      if (in_valid && !in_stall) begin
        e = access_status(req_type, window_sel, data_port, write_data);
        if (cur_typed && e.rd !== cur_rd) report("predicted read_data", e.rd, cur_rd);
        pending_q.push_back(e);
        accepted++;
      end
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) report("unexpected transaction", 1, 0);
        else begin
          e = pending_q.pop_front();
          if (read_data !== e.rd) report("read_data", read_data, e.rd);
          if (config_window !== e.win) report("config_window", config_window, e.win);
          if (fdc_ps2_mode !== e.ps2) report("fdc_ps2_mode", fdc_ps2_mode, e.ps2);
          if (fdc_enabled !== e.fdc) report("fdc_enabled", fdc_enabled, e.fdc);
          if (lpt_enabled !== e.lpt) report("lpt_enabled", lpt_enabled, e.lpt);
          if (uart1_enabled !== e.uart1) report("uart1_enabled", uart1_enabled, e.uart1);
          if (uart2_enabled !== e.uart2) report("uart2_enabled", uart2_enabled, e.uart2);
          if (kbd_enabled !== e.kbd) report("kbd_enabled", kbd_enabled, e.kbd);
          if (mouse_enabled !== e.mouse) report("mouse_enabled", mouse_enabled, e.mouse);
          if (pm_enabled !== e.pm) report("pm_enabled", pm_enabled, e.pm);
        end
        taken++;
        out_hold = calm ? 0 : $urandom_range(0, 5);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver back-pressure, one draw per result
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall = 1'b1;
      out_hold--;
    end else out_stall = 1'b0;
  end

  task automatic access(bit rt, bit ws, bit dp, logic [7:0] wd,
                        bit typed = 0, logic [7:0] rd = 0);
    int gap, n;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type = rt; window_sel = ws; data_port = dp; write_data = wd;
    cur_typed = typed; cur_rd = rd;
    in_valid = 1'b1;
    n = accepted;
    do @(negedge clk); while (accepted == n);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(logic [7:0] idx, logic [7:0] val);
    int n;
    cfg_index = idx; cfg_data = val; cfg_valid = 1'b1;
    n = cfg_done;
    do @(negedge clk); while (cfg_done == n);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_ptr();
    logic [7:0] hot [12] = '{8'h30, 8'h31, 8'h60, 8'h61, 8'h62, 8'h63,
                             8'h70, 8'h71, 8'h74, 8'h75, 8'hf0, 8'hf1};
    case ($urandom_range(0, 3))
      0, 1: return hot[$urandom_range(0, 11)];
      2: return 8'($urandom_range(0, 8'h2f));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_step();
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      access(ACC_WR, PAIR_CFG, PORT_IDX, pick_ptr());
      access(1'($urandom_range(0, 1)), PAIR_CFG, PORT_DAT, 8'($urandom_range(0, 255)));
    end else if (k < 50) begin
      access(ACC_WR, PAIR_CFG, PORT_IDX, GREG_DEVSEL);
      access(ACC_WR, PAIR_CFG, PORT_DAT,
             $urandom_range(0, 9) < 9 ? 8'($urandom_range(0, 7))
                                      : 8'($urandom_range(8, 255)));
    end else if (k < 65) begin
      access(ACC_WR, PAIR_PM, PORT_IDX, 8'($urandom_range(0, 255)));
      access(1'($urandom_range(0, 1)), PAIR_PM, PORT_DAT, 8'($urandom_range(0, 255)));
    end else if (k < 75) begin
      access(ACC_WR, PAIR_CFG, PORT_IDX, GREG_WINDOW);
      access(1'($urandom_range(0, 1)), PAIR_CFG, PORT_DAT, 8'($urandom_range(0, 255)));
    end else begin
      access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             8'($urandom_range(0, 255)));
    end
  endtask

  row_t rows [$] = '{
    '{ACC_RD, PAIR_CFG, PORT_IDX, 8'h00, 1, 8'h00},
    '{ACC_WR, PAIR_CFG, PORT_IDX, GREG_ID, 0, 0},
    '{ACC_RD, PAIR_CFG, PORT_DAT, 8'h00, 1, 8'hff},
    '{ACC_WR, PAIR_CFG, PORT_IDX, GREG_WINDOW, 0, 0},
    '{ACC_RD, PAIR_CFG, PORT_DAT, 8'h00, 1, 8'h0f},
    '{ACC_WR, PAIR_CFG, PORT_DAT, 8'hff, 0, 0},
    '{ACC_WR, PAIR_CFG, PORT_DAT, 8'h00, 0, 0},
    '{ACC_WR, PAIR_CFG, PORT_IDX, GREG_SWRESET, 0, 0},
    '{ACC_WR, PAIR_CFG, PORT_DAT, 8'hff, 0, 0},
    '{ACC_RD, PAIR_CFG, PORT_DAT, 8'h00, 1, 8'h00},
    '{ACC_WR, PAIR_CFG, PORT_IDX, 8'h25, 0, 0},
    '{ACC_WR, PAIR_CFG, PORT_DAT, 8'h5a, 0, 0},
    '{ACC_RD, PAIR_CFG, PORT_DAT, 8'h00, 1, 8'h00},
    '{ACC_WR, PAIR_CFG, PORT_IDX, GREG_DEVSEL, 0, 0},
    '{ACC_WR, PAIR_CFG, PORT_DAT, 8'hff, 0, 0},
    '{ACC_WR, PAIR_CFG, PORT_IDX, 8'h30, 0, 0},
    '{ACC_WR, PAIR_CFG, PORT_DAT, 8'hff, 0, 0},
    '{ACC_RD, PAIR_CFG, PORT_DAT, 8'h00, 1, 8'h00},
    '{ACC_WR, PAIR_PM, PORT_IDX, 8'hff, 0, 0},
    '{ACC_RD, PAIR_PM, PORT_IDX, 8'h00, 1, 8'h07},
    '{ACC_WR, PAIR_PM, PORT_IDX, 8'h00, 0, 0},
    '{ACC_RD, PAIR_PM, PORT_DAT, 8'h00, 1, 8'h79},
    '{ACC_WR, PAIR_PM, PORT_DAT, 8'h00, 0, 0},
    '{ACC_RD, PAIR_CFG, PORT_IDX, 8'h00, 1, 8'h30}
  };

  initial begin
    power_on_state();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    set_reg(CFG_CHIP_ID, 8'hff);
    set_reg(CFG_STRAP, 8'h00);
    foreach (rows[i]) access(rows[i].rt, rows[i].ws, rows[i].dp, rows[i].wd,
                             rows[i].typed, rows[i].rd);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      case (ph)
        0: begin set_reg(CFG_CHIP_ID, 8'h00); set_reg(CFG_STRAP, 8'h01); end
        1: begin
          set_reg(CFG_CHIP_ID, 8'($urandom_range(0, 255)));
          set_reg(CFG_STRAP, 8'h00);
        end
        2: set_reg(CFG_STRAP, 8'hff);
        default: set_reg(CFG_CHIP_ID, 8'($urandom_range(0, 255)));
      endcase
      for (int n = accepted; accepted - n < PHASE_ITEMS;) random_step();
      drain();
    end
    repeat (10) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/scfg_pkg.sv
sv/scfg_ram.sv
sv/scfg_dev_bank.sv
sv/superio_config_register_file_top.sv
tb/sv/testbench.sv
